>>> src/wbps_pkg.sv
// Shared types and constants of the wildcard byte pattern scanner.
// No dependencies.
`timescale 1ns / 1ps

package wbps_pkg;

    localparam int PAT_BYTES  = 16;   // pattern bytes held in the registers
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 5;
    localparam int OFFSET_W   = 32;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_VALUE_LO = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VALUE_HI = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LENGTH   = 3'd3;

    // per-byte compare modes
    localparam logic [1:0] MODE_EXACT = 2'd0;
    localparam logic [1:0] MODE_HIGH  = 2'd1;
    localparam logic [1:0] MODE_LOW   = 2'd2;
    localparam logic [1:0] MODE_ANY   = 2'd3;

    typedef struct packed {
        logic [8*PAT_BYTES-1:0] pat_value;  // byte i at bits 8i+7:8i
        logic [2*PAT_BYTES-1:0] pat_mode;   // byte i at bits 2i+1:2i
        logic [LEN_W-1:0]       pat_len;    // clamped, 1..PATTERN_MAX
    } t_cfg;

endpackage

>>> src/wildcard_byte_pattern_scanner_top.sv
// Wildcard byte pattern scanner, top level: stream ports, window and counters.
// Depends on wbps_pkg, wbps_cfg, wbps_match.
`timescale 1ns / 1ps

// One region byte is taken per clock cycle unless the input side stalls; a match
// shows on the result port in the cycle after the transaction carrying its last
// byte, with the region offset of its first byte. The window compare for all
// pattern bytes runs in parallel in the transaction's cycle. The input side
// stalls only while the output register holds a match not taken downstream.
// Configuration must be written only while the stream is idle; nothing enforces it.

module wildcard_byte_pattern_scanner_top import wbps_pkg::*; #(
    parameter int PATTERN_MAX   = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,    // [7:0] data_byte
    input  logic                  i_s_tuser,    // [0] region_start
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OFFSET_W-1:0]   o_m_tdata,    // [31:0] match_offset
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int DIFF_W = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    t_cfg cfg;

    logic [7:0]               r_win [PATTERN_MAX];
    logic [7:0]               n_win [PATTERN_MAX];
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] pos_base;
    logic [LEN_W-1:0]         r_sup;
    logic [LEN_W-1:0]         n_sup;
    logic [LEN_W-1:0]         sup_base;
    logic                     r_out_valid;
    logic [OFFSET_W-1:0]      r_out_data;
    logic [DIFF_W-1:0]        offset;
    logic                     s_fire;
    logic                     win_hit;
    logic                     hit;

    wbps_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    wbps_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .i_win (n_win),
        .i_cfg (cfg),
        .o_hit (win_hit)
    );

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_fire     = i_s_tvalid && o_s_tready;

    // next window: region start clears the old bytes before the shift
    always_comb begin
        n_win[0] = i_s_tdata;
        for (int i = 1; i < PATTERN_MAX; i++) begin
            n_win[i] = i_s_tuser ? 8'd0 : r_win[i-1];
        end
    end

    always_comb begin
        pos_base = i_s_tuser ? '0 : r_pos;
        sup_base = i_s_tuser ? '0 : r_sup;
        n_pos    = (pos_base == POS_MAX) ? pos_base : pos_base + POSITION_BITS'(1);
        hit      = (sup_base == '0) && (n_pos >= POSITION_BITS'(cfg.pat_len)) && win_hit;
        if (sup_base != '0) begin
            n_sup = sup_base - LEN_W'(1);
        end else if (hit) begin
            n_sup = cfg.pat_len - LEN_W'(1);
        end else begin
            n_sup = '0;
        end
        offset = DIFF_W'(n_pos) - DIFF_W'(cfg.pat_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sup <= '0;
            for (int i = 0; i < PATTERN_MAX; i++) begin
                r_win[i] <= 8'd0;
            end
        end else if (s_fire) begin
            r_pos <= n_pos;
            r_sup <= n_sup;
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire && hit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && hit) begin
            r_out_data <= offset[OFFSET_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> src/wbps_cfg.sv
// Configuration registers and active pattern length clamp.
// Depends on wbps_pkg.
`timescale 1ns / 1ps

module wbps_cfg import wbps_pkg::*; #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    logic [63:0]      r_value_lo;
    logic [63:0]      r_value_hi;
    logic [31:0]      r_mode;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] len_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_lo <= '0;
            r_value_hi <= '0;
            r_mode     <= '0;
            r_len      <= LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_VALUE_LO: r_value_lo <= i_cfg_wdata;
                CFG_VALUE_HI: r_value_hi <= i_cfg_wdata;
                CFG_MODE:     r_mode     <= i_cfg_wdata[31:0];
                CFG_LENGTH:   r_len      <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_len == '0) begin
            len_act = LEN_W'(1);
        end else if (r_len > LEN_W'(PATTERN_MAX)) begin
            len_act = LEN_W'(PATTERN_MAX);
        end else begin
            len_act = r_len;
        end
    end

    assign o_cfg.pat_value = {r_value_hi, r_value_lo};
    assign o_cfg.pat_mode  = r_mode;
    assign o_cfg.pat_len   = len_act;

endmodule

>>> src/wbps_match.sv
// Parallel window compare: every active pattern byte against its window tap.
// Depends on wbps_pkg.
`timescale 1ns / 1ps

module wbps_match import wbps_pkg::*; #(
    parameter int PATTERN_MAX = 16
) (
    input  logic [7:0] i_win [PATTERN_MAX],   // entry 0 newest
    input  t_cfg       i_cfg,
    output logic       o_hit
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [PATTERN_MAX-1:0] byte_ok;

    function automatic logic byte_match(input logic [7:0] data, input logic [7:0] pat,
                                        input logic [1:0] mode);
        logic res;
        unique case (mode)
            MODE_EXACT: res = (data == pat);
            MODE_HIGH:  res = (data[7:4] == pat[7:4]);
            MODE_LOW:   res = (data[3:0] == pat[3:0]);
            MODE_ANY:   res = 1'b1;
            default:    res = 1'b1;
        endcase
        return res;
    endfunction

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_lane
        logic [LEN_W-1:0] back;
        // pattern byte i sits len-1-i places behind the newest byte
        always_comb begin
            back = i_cfg.pat_len - LEN_W'(i) - LEN_W'(1);
            if (LEN_W'(i) >= i_cfg.pat_len) begin
                byte_ok[i] = 1'b1;
            end else begin
                byte_ok[i] = byte_match(i_win[back[IDX_W-1:0]],
                                        i_cfg.pat_value[8*i +: 8],
                                        i_cfg.pat_mode[2*i +: 2]);
            end
        end
    end

    assign o_hit = &byte_ok;

endmodule

>>> src/wbps_checker.sv
// Port-level checks for the wildcard byte pattern scanner, bound to its top.
// Depends on wbps_pkg and wildcard_byte_pattern_scanner_top.
`timescale 1ns / 1ps

module wbps_checker import wbps_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OFFSET_W-1:0]   o_m_tdata
);

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result blocks the input side
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted while result stalled");

    // a new result needs an input transaction in the cycle before
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready))
        else $error("result without input transaction");

    // offset stays put while the result waits
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind wildcard_byte_pattern_scanner_top wbps_checker u_wbps_checker (.*);

>>> bench/testbench.sv
// Self-checking bench for wildcard_byte_pattern_scanner_top: streams region bytes,
// predicts every match offset and compares each result transaction in order.
// Depends on wbps_pkg and the scanner RTL.
`timescale 1ns / 1ps

module testbench;
    import wbps_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_FIRST = CFG_LENGTH + CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LAST  = '1;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEM_TARGET  = 1150;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_COIN} t_rx_style;

    // Predicts match offsets from the accepted byte stream.
    class t_match_scoreboard;
        logic [63:0] pat_lo;
        logic [63:0] pat_hi;
        logic [31:0] pat_mode;
        logic [4:0]  pat_len_code;
        logic [7:0]  window [16];
        logic [31:0] position;
        logic [4:0]  suppress;
        logic [OFFSET_W-1:0] offsets_due [$];
        int errors;

        function new();
            pat_lo = '0;
            pat_hi = '0;
            pat_mode = '0;
            pat_len_code = 5'd1;
            foreach (window[k]) window[k] = '0;
            position = '0;
            suppress = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
            case (addr)
                CFG_VALUE_LO: pat_lo = value;
                CFG_VALUE_HI: pat_hi = value;
                CFG_MODE:     pat_mode = value[31:0];
                CFG_LENGTH:   pat_len_code = value[4:0];
                default: ;
            endcase
        endfunction

        function int active_len();
            if (pat_len_code == 0) return 1;
            if (pat_len_code > PAT_BYTES) return PAT_BYTES;
            return int'(pat_len_code);
        endfunction

        function logic [7:0] pat_byte_of(int idx);
            return (idx < 8) ? pat_lo[8*(idx%8) +: 8] : pat_hi[8*(idx%8) +: 8];
        endfunction

        function logic [1:0] mode_of(int idx);
            return pat_mode[2*idx +: 2];
        endfunction

        function bit byte_hit(int idx, logic [7:0] data);
            logic [7:0] p;
            p = pat_byte_of(idx);
            case (mode_of(idx))
                MODE_EXACT: return data == p;
                MODE_HIGH:  return data[7:4] == p[7:4];
                MODE_LOW:   return data[3:0] == p[3:0];
                default:    return 1'b1;
            endcase
        endfunction

        function void note_byte(logic [7:0] data, logic first);
            int len;
            bit hit;
            len = active_len();
            if (first) begin
                position = '0;
                suppress = '0;
                foreach (window[k]) window[k] = '0;
            end
            for (int k = 15; k > 0; k--) window[k] = window[k-1];
            window[0] = data;
            if (position != '1) position++;
            if (suppress != 0) begin
                suppress--;
                return;
            end
            if (position < len) return;
            hit = 1'b1;
            // pattern byte k sits len-1-k places behind the newest byte
            for (int k = 0; k < len; k++)
                if (!byte_hit(k, window[len-1-k])) hit = 1'b0;
            if (hit) begin
                offsets_due.push_back(OFFSET_W'(position - len));
                suppress = 5'(len - 1);
            end
        endfunction

        function void check_offset(logic [OFFSET_W-1:0] got);
            logic [OFFSET_W-1:0] want;
            if (offsets_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("match at offset %0d with none expected", got);
                return;
            end
            want = offsets_due.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("offset mismatch: expected %0d, got %0d", want, got);
            end
        endfunction

        function int pending();
            return offsets_due.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata;    // [7:0] data_byte
    logic                  i_s_tuser;    // [0] region_start
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OFFSET_W-1:0]   o_m_tdata;    // [31:0] match_offset
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    t_match_scoreboard sb = new();
    t_rx_style rx_style = RX_ALWAYS;
    bit hold_req = 1'b0;
    bit gaps_on = 1'b1;
    int burst_left = 1;
    int items_sent = 0;

    wildcard_byte_pattern_scanner_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_byte(i_s_tdata, i_s_tuser);
            if (o_m_tvalid && i_m_tready) sb.check_offset(o_m_tdata);
        end
    end

    // Result side: stall pattern set per phase, plus a long counted hold-off on request.
    initial begin
        int rx_cyc;
        int hold_left;
        rx_cyc = 0;
        hold_left = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cyc++;
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                case (rx_style)
                    RX_ALWAYS:   i_m_tready <= 1'b1;
                    RX_RANDOM:   i_m_tready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: i_m_tready <= ((rx_cyc % 7) < 4);
                    default:     i_m_tready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic first);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= first;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        if (gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                burst_left = $urandom_range(1, 30);
            end
        end
    endtask

    // Stop sending and let every outstanding match come out.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(addr, value);
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] fitting_byte(input int idx);
        logic [7:0] p;
        logic [7:0] r;
        p = sb.pat_byte_of(idx);
        r = 8'($urandom_range(0, 255));
        case (sb.mode_of(idx))
            MODE_EXACT: return p;
            MODE_HIGH:  return {p[7:4], r[3:0]};
            MODE_LOW:   return {r[7:4], p[3:0]};
            default:    return r;
        endcase
    endfunction

    function automatic logic rare_start();
        return $urandom_range(0, 49) == 0;
    endfunction

    task automatic random_phase(input int count);
        int stop_at;
        int len;
        int kind;
        int cut;
        int reps;
        int r;
        logic [63:0] value;
        logic [31:0] modes;
        logic [7:0]  run_byte;
        stop_at = items_sent + count;

        kind = $urandom_range(0, 19);
        value = {$urandom(), $urandom()};
        if (kind == 0)      value[4:0] = 5'd0;
        else if (kind == 1) value[4:0] = 5'($urandom_range(17, 31));
        else if (kind < 5)  value[4:0] = 5'($urandom_range(9, 16));
        else                value[4:0] = 5'($urandom_range(1, 8));
        write_reg(CFG_LENGTH, value);

        if ($urandom_range(0, 4) == 0) begin
            modes = $urandom();
        end else begin
            for (int k = 0; k < PAT_BYTES; k++) begin
                r = $urandom_range(0, 9);
                modes[2*k +: 2] = (r < 5) ? MODE_EXACT : (r < 7) ? MODE_HIGH :
                                  (r < 9) ? MODE_LOW : MODE_ANY;
            end
        end
        write_reg(CFG_MODE, {$urandom(), modes});
        write_reg(CFG_VALUE_LO, {$urandom(), $urandom()});
        write_reg(CFG_VALUE_HI, {$urandom(), $urandom()});
        // writes to unused indexes must leave the pattern alone
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_ADDR_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                      {$urandom(), $urandom()});

        rx_style = t_rx_style'($urandom_range(0, 3));
        gaps_on = ($urandom_range(0, 3) != 0);
        burst_left = $urandom_range(1, 30);
        len = sb.active_len();

        while (items_sent < stop_at) begin
            kind = $urandom_range(0, 19);
            if (kind < 11) begin
                for (int k = 0; k < len; k++) send_byte(fitting_byte(k), rare_start());
            end else if (kind < 14) begin
                // prefix of an occurrence, then a random byte
                cut = $urandom_range(0, len - 1);
                for (int k = 0; k < cut; k++) send_byte(fitting_byte(k), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (kind < 16) begin
                // run of one byte: overlapping candidates
                reps = len + $urandom_range(1, 4);
                run_byte = fitting_byte(0);
                repeat (reps) send_byte(run_byte, 1'b0);
            end else begin
                reps = $urandom_range(1, 6);
                repeat (reps) send_byte(8'($urandom_range(0, 255)), rare_start());
            end
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_wdata <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset pattern (single zero byte), stream with no region start yet
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        wait_idle();

        // one byte of each compare mode, then partial hit cut by a new region
        write_reg(CFG_ADDR_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), '1);
        write_reg(CFG_VALUE_LO, 64'h0000_0000_00A5_3F12);
        write_reg(CFG_VALUE_HI, {$urandom(), $urandom()});
        write_reg(CFG_MODE, {56'd0, MODE_ANY, MODE_LOW, MODE_HIGH, MODE_EXACT});
        write_reg(CFG_LENGTH, 64'd4);
        send_byte(8'h12, 1'b1);
        send_byte(8'h35, 1'b0);
        send_byte(8'hC5, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h3A, 1'b0);
        send_byte(8'h12, 1'b1);
        wait_idle();

        // zero length acts as one
        write_reg(CFG_VALUE_LO, 64'h0000_0000_0000_00FF);
        write_reg(CFG_LENGTH, 64'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_idle();

        // length above the maximum clamps to 16, all wildcards
        write_reg(CFG_MODE, '1);
        write_reg(CFG_LENGTH, 64'd17);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat (15) send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_idle();

        // every byte matches; the result side holds off so the input backs up
        write_reg(CFG_LENGTH, 64'd1);
        gaps_on = 1'b0;
        rx_style = RX_ALWAYS;
        hold_req = 1'b1;
        repeat (80) send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_idle();

        while (items_sent < ITEM_TARGET) random_phase($urandom_range(60, 120));

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
src/wbps_pkg.sv
src/wbps_cfg.sv
src/wbps_match.sv
src/wildcard_byte_pattern_scanner_top.sv
src/wbps_checker.sv
bench/testbench.sv
